FILE: src/hdc_pkg.sv
`default_nettype none

package hdc_pkg;

    // one date beat
    typedef struct packed {
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [13:0] year_number;
        logic [2:0]  weekday;
    } date_t;

    // one result beat
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] holiday_id;
    } result_t;

    // calendar rule outcome, decided before easter is known
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] holiday_id;
        logic       easter_chk;
    } rule_t;

    // rule outcome carried alongside the easter pipeline
    typedef struct packed {
        rule_t      rule;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } carry_t;

    // register stages inside the computus pipeline
    localparam int EASTER_LAT = 7;

    localparam logic [2:0] MONDAY   = 3'd1;
    localparam logic [2:0] THURSDAY = 3'd4;
    localparam logic [2:0] FRIDAY   = 3'd5;

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_MAR = 4'd2;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_JUL = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_HOLIDAY  = 2'd1;
    localparam logic [1:0] ST_OBSERVED = 2'd2;

    localparam logic [3:0] ID_NEWYEAR      = 4'd0;
    localparam logic [3:0] ID_MLK          = 4'd1;
    localparam logic [3:0] ID_PRESIDENTS   = 4'd2;
    localparam logic [3:0] ID_MEMORIAL     = 4'd3;
    localparam logic [3:0] ID_JUNETEENTH   = 4'd4;
    localparam logic [3:0] ID_JULY4        = 4'd5;
    localparam logic [3:0] ID_LABOR        = 4'd6;
    localparam logic [3:0] ID_COLUMBUS     = 4'd7;
    localparam logic [3:0] ID_VETERANS     = 4'd8;
    localparam logic [3:0] ID_THANKSGIVING = 4'd9;
    localparam logic [3:0] ID_CHRISTMAS    = 4'd10;
    localparam logic [3:0] ID_EASTER       = 4'd11;

    // computus constants
    localparam logic [9:0] H_BIAS   = 10'd15;
    localparam logic [6:0] L_BIAS   = 7'd32;
    localparam logic [8:0] M_LIMIT  = 9'd451;
    localparam logic [7:0] T_BIAS   = 8'd114;
    localparam logic [7:0] T_APRIL  = 8'd124;
    localparam logic [7:0] T_MAR_DAY = 8'd92;
    localparam logic [7:0] T_APR_DAY = 8'd123;

    // year / 100, exact for any 14-bit year
    function automatic logic [7:0] div100(input logic [13:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'd20972;
        return p[28:21];
    endfunction

    // year / 19, exact for any 14-bit year
    function automatic logic [9:0] div19(input logic [13:0] v);
        logic [29:0] p;
        p = 30'(v) * 30'd55189;
        return p[29:20];
    endfunction

    // (b + 8) / 25 for b up to 163
    function automatic logic [2:0] div25(input logic [7:0] v);
        logic [12:0] p;
        p = 13'(v) * 13'd41;
        return p[12:10];
    endfunction

    // x / 3 for x up to 164
    function automatic logic [5:0] div3(input logic [7:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd171;
        return p[14:9];
    endfunction

    // x / 30 for x up to 520
    function automatic logic [4:0] div30(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'd2185;
        return p[20:16];
    endfunction

    // x / 7 for x up to 86
    function automatic logic [3:0] div7(input logic [6:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd147;
        return p[13:10];
    endfunction

endpackage

`default_nettype wire

FILE: src/hdc_rules.sv
`default_nettype none

module hdc_rules
    import hdc_pkg::*;
(
    input  wire date_t date,
    output rule_t      rule
);

    // fixed-date holiday with friday-before / monday-after observance
    function automatic logic [1:0] fixed_rule(input logic [4:0] hol, input logic [4:0] day,
                                              input logic [2:0] wd);
        logic [5:0] day_p1;
        logic [5:0] hol_p1;
        day_p1 = {1'b0, day} + 6'd1;
        hol_p1 = {1'b0, hol} + 6'd1;
        if (day == hol)
            return ST_HOLIDAY;
        else if (day_p1 == {1'b0, hol} && wd == FRIDAY)
            return ST_OBSERVED;
        else if ({1'b0, day} == hol_p1 && wd == MONDAY)
            return ST_OBSERVED;
        else
            return ST_NONE;
    endfunction

    logic [3:0] mon;
    logic [4:0] day;
    logic [2:0] wd;
    logic       monday;
    rule_t      r;

    assign mon    = date.month_index;
    assign day    = date.day_of_month;
    assign wd     = date.weekday;
    assign monday = (wd == MONDAY);

    // priority chain of calendar rules
    always_comb
    begin
        r.status     = ST_NONE;
        r.holiday_id = ID_NEWYEAR;
        r.easter_chk = 1'b0;
        if (mon == MON_DEC && day == 5'd31 && wd == FRIDAY)
        begin
            r.status     = ST_OBSERVED;
            r.holiday_id = ID_NEWYEAR;
        end
        else if (mon == MON_JAN && day == 5'd1)
        begin
            r.status     = ST_HOLIDAY;
            r.holiday_id = ID_NEWYEAR;
        end
        else if (mon == MON_JAN && day == 5'd2 && monday)
        begin
            r.status     = ST_OBSERVED;
            r.holiday_id = ID_NEWYEAR;
        end
        else if (mon == MON_JAN && monday && day inside {[5'd15:5'd21]})
        begin
            r.status     = ST_HOLIDAY;
            r.holiday_id = ID_MLK;
        end
        else if (mon == MON_FEB && monday && day inside {[5'd15:5'd21]})
        begin
            r.status     = ST_HOLIDAY;
            r.holiday_id = ID_PRESIDENTS;
        end
        else if (mon == MON_MAY && monday && day inside {[5'd25:5'd31]})
        begin
            r.status     = ST_HOLIDAY;
            r.holiday_id = ID_MEMORIAL;
        end
        else if (mon == MON_JUN)
        begin
            r.status     = fixed_rule(5'd19, day, wd);
            r.holiday_id = ID_JUNETEENTH;
        end
        else if (mon == MON_JUL)
        begin
            r.status     = fixed_rule(5'd4, day, wd);
            r.holiday_id = ID_JULY4;
        end
        else if (mon == MON_SEP && monday && day <= 5'd7)
        begin
            r.status     = ST_HOLIDAY;
            r.holiday_id = ID_LABOR;
        end
        else if (mon == MON_OCT && monday && day inside {[5'd8:5'd14]})
        begin
            r.status     = ST_HOLIDAY;
            r.holiday_id = ID_COLUMBUS;
        end
        else if (mon == MON_NOV)
        begin
            if (wd == THURSDAY && day inside {[5'd22:5'd28]})
            begin
                r.status     = ST_HOLIDAY;
                r.holiday_id = ID_THANKSGIVING;
            end
            else
            begin
                r.status     = fixed_rule(5'd11, day, wd);
                r.holiday_id = ID_VETERANS;
            end
        end
        else if (mon == MON_DEC)
        begin
            r.status     = fixed_rule(5'd25, day, wd);
            r.holiday_id = ID_CHRISTMAS;
        end
        else
        begin
            r.easter_chk = 1'b1;
        end

        // no holiday means id zero
        if (r.status == ST_NONE)
            r.holiday_id = ID_NEWYEAR;
    end

    assign rule = r;

endmodule

`default_nettype wire

FILE: src/hdc_easter.sv
`default_nettype none

module hdc_easter
    import hdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [13:0] year_number,
    output logic      [3:0]  easter_month,
    output logic      [4:0]  easter_day
);

    // stage 1: century and golden-number quotients
    logic [13:0] y1_reg;
    logic [7:0]  q100_1_reg;
    logic [9:0]  q19_1_reg;

    always_ff @(posedge clk)
    begin
        y1_reg     <= year_number;
        q100_1_reg <= div100(year_number);
        q19_1_reg  <= div19(year_number);
    end

    // stage 2: remainders and f = (b + 8) / 25
    logic [13:0] a_full;
    logic [13:0] c_full;
    logic [4:0]  a2_reg;
    logic [7:0]  b2_reg;
    logic [6:0]  c2_reg;
    logic [2:0]  f2_reg;

    assign a_full = y1_reg - 14'(q19_1_reg) * 14'd19;
    assign c_full = y1_reg - 14'(q100_1_reg) * 14'd100;

    always_ff @(posedge clk)
    begin
        a2_reg <= a_full[4:0];
        b2_reg <= q100_1_reg;
        c2_reg <= c_full[6:0];
        f2_reg <= div25(q100_1_reg + 8'd8);
    end

    // stage 3: g = (b - f + 1) / 3, split b and c
    logic [4:0] a3_reg;
    logic [7:0] b3_reg;
    logic [5:0] d3_reg;
    logic [1:0] e3_reg;
    logic [5:0] g3_reg;
    logic [4:0] i3_reg;
    logic [1:0] k3_reg;

    always_ff @(posedge clk)
    begin
        a3_reg <= a2_reg;
        b3_reg <= b2_reg;
        d3_reg <= b2_reg[7:2];
        e3_reg <= b2_reg[1:0];
        g3_reg <= div3(b2_reg - 8'(f2_reg) + 8'd1);
        i3_reg <= c2_reg[6:2];
        k3_reg <= c2_reg[1:0];
    end

    // stage 4: epact sum before the mod 30
    logic [9:0] s_sum;
    logic [9:0] s4_reg;
    logic [4:0] a4_reg;
    logic [1:0] e4_reg;
    logic [4:0] i4_reg;
    logic [1:0] k4_reg;

    assign s_sum = 10'(a3_reg) * 10'd19 + 10'(b3_reg) - 10'(d3_reg) - 10'(g3_reg) + H_BIAS;

    always_ff @(posedge clk)
    begin
        s4_reg <= s_sum;
        a4_reg <= a3_reg;
        e4_reg <= e3_reg;
        i4_reg <= i3_reg;
        k4_reg <= k3_reg;
    end

    // stage 5: h = s mod 30
    logic [9:0] h_full;
    logic [4:0] h5_reg;
    logic [4:0] a5_reg;
    logic [1:0] e5_reg;
    logic [4:0] i5_reg;
    logic [1:0] k5_reg;

    assign h_full = s4_reg - 10'(div30(s4_reg)) * 10'd30;

    always_ff @(posedge clk)
    begin
        h5_reg <= h_full[4:0];
        a5_reg <= a4_reg;
        e5_reg <= e4_reg;
        i5_reg <= i4_reg;
        k5_reg <= k4_reg;
    end

    // stage 6: l = (32 + 2e + 2i - h - k) mod 7
    logic [6:0] u_sum;
    logic [6:0] l_full;
    logic [2:0] l6_reg;
    logic [4:0] h6_reg;
    logic [4:0] a6_reg;

    assign u_sum  = L_BIAS + {4'd0, e5_reg, 1'b0} + {1'b0, i5_reg, 1'b0}
                    - 7'(h5_reg) - 7'(k5_reg);
    assign l_full = u_sum - 7'(div7(u_sum)) * 7'd7;

    always_ff @(posedge clk)
    begin
        l6_reg <= l_full[2:0];
        h6_reg <= h5_reg;
        a6_reg <= a5_reg;
    end

    // stage 7: m and the day-of-spring offset t
    logic [8:0] m_sum;
    logic       m_bit;
    logic [7:0] t_next;
    logic [7:0] t7_reg;

    assign m_sum  = 9'(a6_reg) + 9'(h6_reg) * 9'd11 + 9'(l6_reg) * 9'd22;
    assign m_bit  = (m_sum >= M_LIMIT);
    assign t_next = 8'(h6_reg) + 8'(l6_reg) + T_BIAS - (m_bit ? 8'd7 : 8'd0);

    always_ff @(posedge clk)
    begin
        t7_reg <= t_next;
    end

    // t falls in march or april only
    logic [7:0] eday_full;

    assign eday_full    = (t7_reg >= T_APRIL) ? (t7_reg - T_APR_DAY) : (t7_reg - T_MAR_DAY);
    assign easter_month = (t7_reg >= T_APRIL) ? MON_APR : MON_MAR;
    assign easter_day   = eday_full[4:0];

endmodule

`default_nettype wire

FILE: src/holiday_date_classifier.sv
`default_nettype none

// holiday date classifier
//
// input channel: a date beat (month, day, year, weekday) is taken at each
// rising edge with start high and busy low. busy is never raised, so a new
// date can be started in every cycle.
// output channel: result_valid is high for exactly one cycle with the
// classification (status and holiday id) on result; the receiver has to take
// it in that cycle.
// throughput: one date per cycle. the depth is set by the seven-stage
// easter computus (constant-divisor quotients, mod 30, mod 7, final offset);
// the calendar rules are decided at the input and ride along beside it,
// and one output register merges the two.
// results leave in the order the dates came in.
// reset: rst_n clears the valid bits of every stage, so no result comes out
// until a new date is started; payload registers are not reset.
module holiday_date_classifier
    import hdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire date_t   date,
    output logic         result_valid,
    output result_t      result
);

    logic   accept;
    rule_t  rule_in;
    carry_t carry_in;
    logic [3:0] easter_month;
    logic [4:0] easter_day;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // calendar rules at the input
    hdc_rules u_rules (
        .date (date),
        .rule (rule_in)
    );

    // computus pipeline on the year
    hdc_easter u_easter (
        .clk          (clk),
        .year_number  (date.year_number),
        .easter_month (easter_month),
        .easter_day   (easter_day)
    );

    assign carry_in.rule         = rule_in;
    assign carry_in.month_index  = date.month_index;
    assign carry_in.day_of_month = date.day_of_month;

    // delay line matching the easter pipeline
    carry_t carry_reg [EASTER_LAT];
    logic   vld_reg   [EASTER_LAT];

    always_ff @(posedge clk)
    begin
        carry_reg[0] <= carry_in;
        for (int s = 1; s < EASTER_LAT; s++)
        begin
            carry_reg[s] <= carry_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < EASTER_LAT; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int s = 1; s < EASTER_LAT; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // merge easter match with the rule outcome
    carry_t  last;
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;

    assign last = carry_reg[EASTER_LAT-1];

    always_comb
    begin
        result_next.status     = last.rule.status;
        result_next.holiday_id = last.rule.holiday_id;
        if (last.rule.easter_chk && last.month_index == easter_month
            && last.day_of_month == easter_day)
        begin
            result_next.status     = ST_HOLIDAY;
            result_next.holiday_id = ID_EASTER;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= vld_reg[EASTER_LAT-1];
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

FILE: verif/holiday_date_checker.sv
`timescale 1ns / 100ps

module holiday_date_checker
    import hdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire date_t   date,
    input  wire logic    result_valid,
    input  wire result_t result,
    output int           fail_count,
    output int           pending_count
);

    localparam int JUNETEENTH_DAY = 19;
    localparam int JULY4_DAY      = 4;
    localparam int VETERANS_DAY   = 11;
    localparam int CHRISTMAS_DAY  = 25;

    // classifications of dates taken but not yet answered, oldest first
    result_t expected_classes[$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    // gregorian computus, true when the date is easter sunday of that year
    function automatic logic is_easter_sunday(input logic [3:0] mon, input logic [4:0] day,
                                              input logic [13:0] yr);
        int y, a, b, c, d, e, f, g, h, i, k, l, m, t;
        y = int'(yr);
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        i = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * i - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        t = h + l - 7 * m + 114;
        return (int'(mon) == t / 31 - 1) && (int'(day) == t % 31 + 1);
    endfunction

    // holiday on a fixed day, with friday-before and monday-after observance
    function automatic logic [1:0] fixed_day_status(input int hol, input logic [4:0] day,
                                                    input logic [2:0] wd);
        int dn;
        dn = int'(day);
        if (dn == hol)
            return ST_HOLIDAY;
        if (dn + 1 == hol && wd == FRIDAY)
            return ST_OBSERVED;
        if (dn == hol + 1 && wd == MONDAY)
            return ST_OBSERVED;
        return ST_NONE;
    endfunction

    // expected classification of one date
    function automatic result_t classify_date(input date_t dt);
        result_t r;
        logic    monday;
        int      dn;
        monday       = (dt.weekday == MONDAY);
        dn           = int'(dt.day_of_month);
        r.status     = ST_NONE;
        r.holiday_id = ID_NEWYEAR;
        if (dt.month_index == MON_DEC && dn == 31 && dt.weekday == FRIDAY)
        begin
            r.status = ST_OBSERVED;
            r.holiday_id = ID_NEWYEAR;
        end
        else if (dt.month_index == MON_JAN && dn == 1)
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_NEWYEAR;
        end
        else if (dt.month_index == MON_JAN && dn == 2 && monday)
        begin
            r.status = ST_OBSERVED;
            r.holiday_id = ID_NEWYEAR;
        end
        else if (dt.month_index == MON_JAN && monday && dn >= 15 && dn <= 21)
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_MLK;
        end
        else if (dt.month_index == MON_FEB && monday && dn >= 15 && dn <= 21)
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_PRESIDENTS;
        end
        else if (dt.month_index == MON_MAY && monday && dn >= 25 && dn <= 31)
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_MEMORIAL;
        end
        else if (dt.month_index == MON_JUN)
        begin
            r.status = fixed_day_status(JUNETEENTH_DAY, dt.day_of_month, dt.weekday);
            r.holiday_id = ID_JUNETEENTH;
        end
        else if (dt.month_index == MON_JUL)
        begin
            r.status = fixed_day_status(JULY4_DAY, dt.day_of_month, dt.weekday);
            r.holiday_id = ID_JULY4;
        end
        else if (dt.month_index == MON_SEP && monday && dn <= 7)
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_LABOR;
        end
        else if (dt.month_index == MON_OCT && monday && dn >= 8 && dn <= 14)
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_COLUMBUS;
        end
        else if (dt.month_index == MON_NOV)
        begin
            if (dt.weekday == THURSDAY && dn >= 22 && dn <= 28)
            begin
                r.status = ST_HOLIDAY;
                r.holiday_id = ID_THANKSGIVING;
            end
            else
            begin
                r.status = fixed_day_status(VETERANS_DAY, dt.day_of_month, dt.weekday);
                r.holiday_id = ID_VETERANS;
            end
        end
        else if (dt.month_index == MON_DEC)
        begin
            r.status = fixed_day_status(CHRISTMAS_DAY, dt.day_of_month, dt.weekday);
            r.holiday_id = ID_CHRISTMAS;
        end
        else if (is_easter_sunday(dt.month_index, dt.day_of_month, dt.year_number))
        begin
            r.status = ST_HOLIDAY;
            r.holiday_id = ID_EASTER;
        end
        // no holiday id without a holiday
        if (r.status == ST_NONE)
            r.holiday_id = ID_NEWYEAR;
        return r;
    endfunction

    // compare each result beat with the oldest expectation, then record new dates
    always @(posedge clk)
    begin : compare_proc
        result_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_classes.size() == 0)
                begin
                    $error("result beat with no date pending: status %0d holiday_id %0d",
                           result.status, result.holiday_id);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_classes.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, result.status);
                        fail_count = fail_count + 1;
                    end
                    if (result.holiday_id !== want.holiday_id)
                    begin
                        $error("holiday_id mismatch: expected %0d, actual %0d",
                               want.holiday_id, result.holiday_id);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_classes.push_back(classify_date(date));
            pending_count = expected_classes.size();
        end
    end

endmodule

FILE: verif/tb_holiday_date_classifier.sv
`timescale 1ns / 100ps

module tb_holiday_date_classifier;
    import hdc_pkg::*;

    localparam int RANDOM_DATES = 650;
    localparam int PHASES       = 4;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = EASTER_LAT + 8;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    date_t   date  = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    int fail_count;
    int pending_count;
    int cycle_count  = 0;
    int dates_sent   = 0;
    int easter_sent  = 0;
    int noise_sent   = 0;
    int idle_percent = 0;

    // sender idle share per phase: none, heavy, light, none
    int phase_idle [PHASES] = '{0, 75, 11, 0};

    // directed dates: every rule, both observance sides, easter, field extremes
    date_t directed_dates [25] = '{
        '{MON_DEC, 5'd31, 14'd2021, FRIDAY},
        '{MON_JAN, 5'd1,  14'd2023, 3'd7},
        '{MON_JAN, 5'd2,  14'd2023, MONDAY},
        '{MON_JAN, 5'd15, 14'd2024, MONDAY},
        '{MON_FEB, 5'd21, 14'd2022, MONDAY},
        '{MON_MAY, 5'd31, 14'd2021, MONDAY},
        '{MON_JUN, 5'd18, 14'd2021, FRIDAY},
        '{MON_JUN, 5'd20, 14'd2022, MONDAY},
        '{MON_JUL, 5'd4,  14'd2024, THURSDAY},
        '{MON_JUL, 5'd3,  14'd2020, FRIDAY},
        '{MON_SEP, 5'd1,  14'd2025, MONDAY},
        '{MON_OCT, 5'd14, 14'd2024, MONDAY},
        '{MON_NOV, 5'd22, 14'd2018, THURSDAY},
        '{MON_NOV, 5'd11, 14'd2024, MONDAY},
        '{MON_NOV, 5'd12, 14'd2023, MONDAY},
        '{MON_NOV, 5'd10, 14'd2023, FRIDAY},
        '{MON_DEC, 5'd25, 14'd2024, 3'd3},
        '{MON_DEC, 5'd24, 14'd2021, FRIDAY},
        '{MON_DEC, 5'd26, 14'd2022, MONDAY},
        '{MON_MAR, 5'd31, 14'd2024, 3'd0},
        '{MON_APR, 5'd20, 14'd2025, 3'd0},
        '{4'd15,   5'd31, 14'd16383, 3'd7},
        '{MON_JAN, 5'd0,  14'd0,    3'd0},
        '{MON_JUN, 5'd19, 14'd9999, 3'd6},
        '{MON_NOV, 5'd28, 14'd1583, THURSDAY}
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    holiday_date_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .date         (date),
        .result_valid (result_valid),
        .result       (result)
    );

    holiday_date_checker CHK (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .date          (date),
        .result_valid  (result_valid),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one date beat, with random idle cycles ahead of it
    task automatic send_date(input date_t d);
        while ($urandom_range(99) < idle_percent)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        date  <= d;
        @(negedge clk);
        while (busy)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        dates_sent++;
    endtask

    // hold off until every pending classification has come back
    task automatic wait_all_results;
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        @(posedge clk);
    endtask

    // easter sunday of a year, found by scanning march and april
    function automatic date_t easter_date(input logic [13:0] yr);
        date_t   d;
        result_t r;
        d.year_number = yr;
        d.weekday     = 3'd0;
        for (int mon = int'(MON_MAR); mon <= int'(MON_APR); mon++)
        begin
            for (int dn = 1; dn <= 31; dn++)
            begin
                d.month_index  = 4'(mon);
                d.day_of_month = 5'(dn);
                r = CHK.classify_date(d);
                if (r.status == ST_HOLIDAY && r.holiday_id == ID_EASTER)
                    return d;
            end
        end
        return d;
    endfunction

    // a date close to one of the calendar rules
    function automatic date_t near_holiday_date();
        date_t d;
        d.year_number = 14'($urandom_range(9999, 1583));
        case ($urandom_range(8))
            0:
            begin
                d.month_index  = MON_JAN;
                d.day_of_month = $urandom_range(1) ? 5'($urandom_range(3, 1))
                                                   : 5'($urandom_range(22, 14));
            end
            1:
            begin
                d.month_index  = MON_FEB;
                d.day_of_month = 5'($urandom_range(22, 14));
            end
            2:
            begin
                d.month_index  = MON_MAY;
                d.day_of_month = 5'($urandom_range(31, 24));
            end
            3:
            begin
                d.month_index  = MON_JUN;
                d.day_of_month = 5'($urandom_range(21, 17));
            end
            4:
            begin
                d.month_index  = MON_JUL;
                d.day_of_month = 5'($urandom_range(6, 2));
            end
            5:
            begin
                d.month_index  = MON_SEP;
                d.day_of_month = 5'($urandom_range(8, 1));
            end
            6:
            begin
                d.month_index  = MON_OCT;
                d.day_of_month = 5'($urandom_range(15, 7));
            end
            7:
            begin
                d.month_index  = MON_NOV;
                d.day_of_month = $urandom_range(1) ? 5'($urandom_range(13, 9))
                                                   : 5'($urandom_range(29, 21));
            end
            default:
            begin
                d.month_index  = MON_DEC;
                d.day_of_month = $urandom_range(1) ? 5'($urandom_range(27, 23))
                                                   : 5'($urandom_range(31, 30));
            end
        endcase
        case ($urandom_range(3))
            0:       d.weekday = MONDAY;
            1:       d.weekday = THURSDAY;
            2:       d.weekday = FRIDAY;
            default: d.weekday = 3'($urandom_range(7));
        endcase
        return d;
    endfunction

    initial
    begin : stimulus
        date_t d;
        int    per_phase;
        int    kind;
        per_phase = RANDOM_DATES / PHASES;

        // reset held low, then released before the first date
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed dates back to back
        foreach (directed_dates[i])
            send_date(directed_dates[i]);
        wait_all_results;

        // random dates, one idle setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            idle_percent = phase_idle[phase];
            for (int n = 0; n < per_phase + (phase == PHASES - 1 ? RANDOM_DATES % PHASES : 0);
                 n++)
            begin
                if (n == per_phase / 2)
                    wait_all_results;
                kind = $urandom_range(99);
                if (kind < 15)
                begin
                    d = easter_date(14'($urandom_range(9999, 1583)));
                    easter_sent++;
                end
                else if (kind < 55)
                    d = near_holiday_date();
                else if (kind < 90)
                begin
                    d.month_index  = 4'($urandom_range(11));
                    d.day_of_month = 5'($urandom_range(31, 1));
                    d.year_number  = 14'($urandom_range(9999, 1583));
                    d.weekday      = 3'($urandom_range(6));
                end
                else
                begin
                    // raw bits: months above december, day zero, weekday seven, any year
                    d = date_t'(26'($urandom));
                    noise_sent++;
                end
                send_date(d);
            end
        end

        // drain, then let the pipeline run empty
        wait_all_results;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d dates: 25 directed, %0d easter sundays, %0d raw-bit dates,",
                 dates_sent, easter_sent, noise_sent);
        $display("sender idle shares of 0, 75 and 11 percent, with full drains between");
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
